// ===== hdl/csr_pkg.sv =====
// Shared constants, types and control structs for the circle span rasterizer.
package csr_pkg;

  localparam int COORD_BITS  = 12;
  localparam int MAX_RADIUS  = 63;
  localparam int IN_XY_BITS  = 12;
  localparam int RADIUS_BITS = 6;
  localparam int ARG_BITS    = 12;
  localparam int ROOT_BITS   = 6;
  localparam int OUT_BITS    = 14;

  localparam logic [IN_XY_BITS-1:0]  COORD_MASK = IN_XY_BITS'((33'd1 << COORD_BITS) - 33'd1);
  localparam logic [RADIUS_BITS-1:0] RADIUS_MAX = RADIUS_BITS'(MAX_RADIUS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARG,
    S_ROOT_GO,
    S_ROOT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic arg_load;
    logic root_start;
    logic emit;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic no_rows;
    logic last;
    logic root_busy;
    logic out_busy;
  } stat_t;

endpackage

// ===== hdl/csr_sqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
module csr_sqrt
  import csr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [ARG_BITS-1:0]  arg,
  output logic                 busy,
  output logic [ROOT_BITS-1:0] root
);

  localparam logic [ARG_BITS-1:0] FIRST_BIT = ARG_BITS'(1) << (2 * (ROOT_BITS - 1));

  logic [ARG_BITS-1:0] bit_r, bit_nxt;
  logic [ARG_BITS-1:0] rem_r, rem_nxt;
  logic [ARG_BITS-1:0] root_r, root_nxt;
  logic [ARG_BITS:0]   trial;

  assign trial = {1'b0, root_r} + {1'b0, bit_r};

  always_comb begin
    bit_nxt  = bit_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (start) begin
      bit_nxt  = FIRST_BIT;
      rem_nxt  = arg;
      root_nxt = '0;
    end else if (bit_r != '0) begin
      bit_nxt = bit_r >> 2;
      if ({1'b0, rem_r} >= trial) begin
        rem_nxt  = rem_r - trial[ARG_BITS-1:0];
        root_nxt = (root_r >> 1) + bit_r;
      end else begin
        root_nxt = root_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r <= '0;
    end else begin
      bit_r <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign busy = (bit_r != '0);
  assign root = root_r[ROOT_BITS-1:0];

endmodule

// ===== hdl/csr_dp.sv =====
// Datapath: held command, row offset, root argument, square root and result register.
module csr_dp
  import csr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  logic [IN_XY_BITS-1:0]    cx_r, cy_r;
  logic [RADIUS_BITS-1:0]   r_r, dy_r;
  logic                     mode_r;
  logic [ARG_BITS-1:0]      arg_r;
  logic [RADIUS_BITS-1:0]   in_radius, sat_radius;
  logic [RADIUS_BITS:0]     span;
  logic [2*RADIUS_BITS:0]   prod;
  logic                     root_busy;
  logic [ROOT_BITS-1:0]     root;
  logic [OUT_BITS-1:0]      cx_w, cy_w, r_w, dy_w, dx_w;
  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_BITS-1:0]      xl_r, xr_r, ylo_r, yup_r;
  logic                     ends_r, last_r;

  assign in_radius  = in_tdata[2*IN_XY_BITS +: RADIUS_BITS];
  assign sat_radius = (in_radius > RADIUS_MAX) ? RADIUS_MAX : in_radius;

  assign span = {r_r, 1'b0} - {1'b0, dy_r};
  assign prod = dy_r * span;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cy_r   <= '0;
      r_r    <= '0;
      mode_r <= 1'b0;
      dy_r   <= '0;
    end else begin
      if (cmd.load) begin
        cx_r   <= in_tdata[IN_XY_BITS-1:0] & COORD_MASK;
        cy_r   <= in_tdata[IN_XY_BITS +: IN_XY_BITS] & COORD_MASK;
        r_r    <= sat_radius;
        mode_r <= in_tuser;
        dy_r   <= in_tuser ? RADIUS_BITS'(0) : RADIUS_BITS'(1);
      end else if (cmd.step) begin
        dy_r <= dy_r + RADIUS_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.arg_load) begin
      if (dy_r == '0) begin
        arg_r <= ARG_BITS'({r_r, 1'b0});
      end else begin
        arg_r <= prod[ARG_BITS-1:0];
      end
    end
  end

  csr_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.root_start),
    .arg   (arg_r),
    .busy  (root_busy),
    .root  (root)
  );

  assign cx_w = OUT_BITS'(cx_r);
  assign cy_w = OUT_BITS'(cy_r);
  assign r_w  = OUT_BITS'(r_r);
  assign dy_w = OUT_BITS'(dy_r);
  assign dx_w = OUT_BITS'(root);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      xl_r   <= cx_w - dx_w;
      xr_r   <= cx_w + dx_w;
      ylo_r  <= cy_w + r_w - dy_w;
      yup_r  <= cy_w - r_w + dy_w;
      ends_r <= mode_r && (dy_r != '0);
      last_r <= (dy_r == r_r);
    end
  end

  assign stat.no_rows   = !in_tuser && (sat_radius == '0);
  assign stat.last      = (dy_r == r_r);
  assign stat.root_busy = root_busy;
  assign stat.out_busy  = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {yup_r, ylo_r, xr_r, xl_r};
  assign out_tuser  = ends_r;
  assign out_tlast  = last_r;

endmodule

// ===== hdl/csr_ctrl.sv =====
// Controller: sequences command load, root argument, square root and result word per row.
module csr_ctrl
  import csr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_tvalid,
  output logic  in_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (!stat.no_rows) begin
            state_nxt = S_ARG;
          end
        end
      end
      S_ARG: begin
        cmd.arg_load = 1'b1;
        state_nxt    = S_ROOT_GO;
      end
      S_ROOT_GO: begin
        cmd.root_start = 1'b1;
        state_nxt      = S_ROOT;
      end
      S_ROOT: begin
        if (!stat.root_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit = 1'b1;
          if (stat.last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.step  = 1'b1;
            state_nxt = S_ARG;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/circle_span_rasterizer.sv =====
// Top level of the circle span rasterizer: controller plus datapath.
//
// Input channel (in_*): one word is one circle command (center, radius, mode).
// Output channel (out_*): one word per row pair: span ends and the two rows.
// Fill mode gives r words and nothing for a zero radius; outline mode gives a
// cap word first and then r words with out_tuser set (end pixels only).
// out_tlast marks the final word of a command.
// Each word passes through root argument load, root start, the bit-serial square
// root (six root bits and a done check) and the output load.
// A command occupies the block longest at the largest radius in outline mode;
// a zero-radius fill command is taken and gives no words.
// in_tready is high only between commands; the next command is taken while
// the final word still waits in the output register.
// When the receiver stalls, the output register holds its word and the
// sequencer waits with the next row ready.
// Synchronous active-low reset clears the sequencer, held command and valid.
module circle_span_rasterizer
  import csr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // center_x[11:0], center_y[23:12], radius[29:24], zero
  input  logic        in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // x_left[13:0], x_right[27:14], y_lower_half[41:28],
                                  // y_upper_half[55:42]
  output logic        out_tuser,  // endpoints_only
  output logic        out_tlast
);

  cmd_t  cmd;
  stat_t stat;

  csr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  csr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
